FILE: hdl/zlsd_pkg.sv
// Shared types, constants and the CRC-32 table for the legacy ZIP stream decryptor.
package zlsd_pkg;

    localparam int unsigned HEADER_LEN = 12;
    localparam int unsigned CNT_W      = 4;

    localparam logic [31:0] KEY0_INIT = 32'h1234_5678;
    localparam logic [31:0] KEY1_INIT = 32'h2345_6789;
    localparam logic [31:0] KEY2_INIT = 32'h3456_7890;
    localparam logic [31:0] LCG_MULT  = 32'd134775813;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

    localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(HEADER_LEN - 1);
    localparam logic [CNT_W-1:0] HDR_HOLD  = CNT_W'(HEADER_LEN - 2);
    localparam logic [CNT_W-1:0] HDR_FULL  = CNT_W'(HEADER_LEN);

    // Input function codes
    localparam logic FUNC_PASSWORD = 1'b0;
    localparam logic FUNC_CIPHER   = 1'b1;

    typedef logic [255:0][31:0] crc_tab_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture input transfer, apply restart
        logic stream;   // keystream multiply
        logic key0;     // plain byte, key0 CRC, key1 sum, header logic
        logic key1;     // key1 congruential step
        logic key2;     // key2 CRC, result into output register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_stall;  // output register holds an untaken result
    } dp_stat_t;

    // Byte-wise reflected CRC-32 table, built at elaboration
    function automatic crc_tab_t crc_table_gen();
        crc_tab_t    tab;
        logic [31:0] x;
        for (int i = 0; i < 256; i++) begin
            x = 32'(i);
            for (int k = 0; k < 8; k++) begin
                x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
            end
            tab[i] = x;
        end
        return tab;
    endfunction

    localparam crc_tab_t CRC_TABLE = crc_table_gen();

    // One CRC-32 byte update by table lookup
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [7:0] idx;
        idx = crc[7:0] ^ b;
        return (crc >> 8) ^ CRC_TABLE[idx];
    endfunction

endpackage

FILE: hdl/zlsd_ctrl.sv
// Sequencing state machine for the legacy ZIP stream decryptor.
module zlsd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  zlsd_pkg::dp_stat_t stat,
    output zlsd_pkg::dp_cmd_t  cmd
);
    import zlsd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_KS   = 5'b00010,
        ST_KEY0 = 5'b00100,
        ST_KEY1 = 5'b01000,
        ST_KEY2 = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_KS;
                end
            end
            ST_KS:
            begin
                cmd.stream = 1'b1;
                state_next = ST_KEY0;
            end
            ST_KEY0:
            begin
                cmd.key0   = 1'b1;
                state_next = ST_KEY1;
            end
            ST_KEY1:
            begin
                cmd.key1   = 1'b1;
                state_next = ST_KEY2;
            end
            ST_KEY2:
            begin
                // wait until the output register can take the result
                if (!stat.out_stall)
                begin
                    cmd.key2   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/zlsd_dp.sv
// Key registers, keystream multiply, CRC updates and header check datapath.
module zlsd_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  zlsd_pkg::dp_cmd_t  cmd,
    output zlsd_pkg::dp_stat_t stat,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               func,
    input  logic               restart,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         plain_byte,
    output logic               check_done,
    output logic               check_ok
);
    import zlsd_pkg::*;

    logic [31:0]      key0_reg, key0_next;
    logic [31:0]      key1_reg, key1_next;
    logic [31:0]      key2_reg, key2_next;
    logic [CNT_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]       held_reg, held_next;
    logic [15:0]      chk_reg;
    logic             func_reg;
    logic [7:0]       data_reg;
    logic [7:0]       ks_reg;
    logic [7:0]       plain_reg, plain_next;
    logic             done_reg, done_next;
    logic             ok_reg, ok_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_plain_reg;
    logic             out_done_reg;
    logic             out_ok_reg;

    logic [15:0] ks_term;
    logic [31:0] ks_prod;
    logic [7:0]  absorb;
    logic [31:0] key0_crc;
    logic [31:0] lcg_prod;

    // Keystream: t * (t ^ 1), bits 15:8
    assign ks_term = key2_reg[15:0] | 16'h0002;
    assign ks_prod = 32'(ks_term) * 32'(ks_term ^ 16'h0001);

    // Plain byte and the byte that advances the keys
    assign plain_next = (func_reg == FUNC_CIPHER) ? (data_reg ^ ks_reg) : 8'h00;
    assign absorb     = (func_reg == FUNC_CIPHER) ? plain_next : data_reg;
    assign key0_crc   = crc_byte(key0_reg, absorb);
    // only the low 32 bits of the congruential product are kept
    assign lcg_prod   = key1_reg * LCG_MULT;

    // Key and header next-state logic
    always_comb
    begin
        key0_next    = key0_reg;
        key1_next    = key1_reg;
        key2_next    = key2_reg;
        hdr_cnt_next = hdr_cnt_reg;
        held_next    = held_reg;
        done_next    = done_reg;
        ok_next      = ok_reg;
        if (cmd.load)
        begin
            if (restart)
            begin
                key0_next    = KEY0_INIT;
                key1_next    = KEY1_INIT;
                key2_next    = KEY2_INIT;
                hdr_cnt_next = '0;
            end
        end
        else if (cmd.key0)
        begin
            key0_next = key0_crc;
            key1_next = key1_reg + {24'h0, key0_crc[7:0]};
            done_next = 1'b0;
            ok_next   = 1'b0;
            if ((func_reg == FUNC_CIPHER) && (hdr_cnt_reg < HDR_FULL))
            begin
                if (hdr_cnt_reg == HDR_HOLD)
                begin
                    held_next = plain_next;
                end
                if (hdr_cnt_reg == HDR_LAST)
                begin
                    done_next = 1'b1;
                    ok_next   = ({plain_next, held_reg} == chk_reg);
                end
                hdr_cnt_next = hdr_cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.key1)
        begin
            key1_next = lcg_prod + 32'd1;
        end
        else if (cmd.key2)
        begin
            key2_next = crc_byte(key2_reg, key1_reg[31:24]);
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.key2)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.out_stall = out_valid_reg && !out_ready;

    // Control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg      <= KEY0_INIT;
            key1_reg      <= KEY1_INIT;
            key2_reg      <= KEY2_INIT;
            hdr_cnt_reg   <= '0;
            held_reg      <= 8'h00;
            chk_reg       <= 16'h0000;
            done_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key0_reg      <= key0_next;
            key1_reg      <= key1_next;
            key2_reg      <= key2_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            held_reg      <= held_next;
            done_reg      <= done_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                chk_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            data_reg <= data_byte;
        end
        if (cmd.stream)
        begin
            ks_reg <= ks_prod[15:8];
        end
        if (cmd.key0)
        begin
            plain_reg <= plain_next;
        end
        if (cmd.key2)
        begin
            out_plain_reg <= plain_reg;
            out_done_reg  <= done_reg;
            out_ok_reg    <= ok_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign plain_byte = out_plain_reg;
    assign check_done = out_done_reg;
    assign check_ok   = out_ok_reg;

endmodule

FILE: hdl/zip_legacy_stream_decrypt.sv
// Top level of the legacy ZIP (ZipCrypto) stream decryptor.
//
// Each input transfer carries one byte: a password byte (func 0) only
// advances the three keys, a cipher byte (func 1) is decrypted and its plain
// byte advances the keys; restart reloads the initial keys first. One result
// transfer follows each input transfer. After the input transfer, four datapath
// steps run in turn - the 16x16 keystream multiply, the key0 CRC lookup with
// the key1 add, the 32-bit key1 congruential multiply, and the key2 CRC lookup,
// which loads the output register and raises out_valid. The input is ready again
// in the cycle after that load, so a new byte is taken only once the result of
// the previous one is in the output register; while an earlier result waits
// untaken in the output register, the last step and with it the input are held.
// On the twelfth cipher byte after a restart, check_done rises and check_ok
// tells whether plain header bytes 11:10 match the check value written through
// cfg_wr_en/cfg_wr_data; the user must write it only while idle, and the block
// itself does not enforce this.
module zip_legacy_stream_decrypt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic        restart,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  plain_byte,
    output logic        check_done,
    output logic        check_ok
);
    import zlsd_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    zlsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Key and check datapath
    zlsd_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .restart     (restart),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .plain_byte  (plain_byte),
        .check_done  (check_done),
        .check_ok    (check_ok)
    );

endmodule

FILE: hdl/zlsd_checker.sv
// Port-level assertions for the legacy ZIP stream decryptor, bound to the top level.
module zlsd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] plain_byte,
    input logic       check_done,
    input logic       check_ok
);

    // A match is only reported together with the header check
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && check_ok) |-> check_done)
    else $error("check_ok without check_done");

    // No input transfer while a byte is still being worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input taken during byte processing");

    // A result never appears the cycle after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result too early after input transfer");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(plain_byte)
            && $stable(check_done) && $stable(check_ok)))
    else $error("stalled result changed");

endmodule

bind zip_legacy_stream_decrypt zlsd_checker u_zlsd_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plain_byte (plain_byte),
    .check_done (check_done),
    .check_ok   (check_ok)
);

FILE: sim/zipcrypto_result_checker.sv
// ZipCrypto key schedule helpers and the result checker for the stream decryptor testbench.
`timescale 1ns / 100ps

package zipcrypto_tb_pkg;

    import zlsd_pkg::*;

    // The three cipher keys, key 0 in the top word
    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
    } key_set_t;

    localparam key_set_t KEYS_INIT = {KEY0_INIT, KEY1_INIT, KEY2_INIT};

    // Reflected CRC-32, one byte, shifted out bit by bit
    function automatic logic [31:0] crc32_shift(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] x;
        x = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

    // Key update driven by one plain (or password) byte
    function automatic key_set_t keys_absorb(input key_set_t ks, input logic [7:0] b);
        key_set_t nk;
        nk.k0 = crc32_shift(ks.k0, b);
        nk.k1 = (ks.k1 + {24'h0, nk.k0[7:0]}) * LCG_MULT + 32'd1;
        nk.k2 = crc32_shift(ks.k2, nk.k1[31:24]);
        return nk;
    endfunction

    // Keystream byte from the low half of key 2
    function automatic logic [7:0] keystream_byte(input key_set_t ks);
        logic [31:0] t;
        logic [31:0] prod;
        t    = {16'h0, ks.k2[15:0] | 16'h0002};
        prod = t * (t ^ 32'd1);
        return prod[15:8];
    endfunction

endpackage

module zipcrypto_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        func,
    input  logic        restart,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  plain_byte,
    input  logic        check_done,
    input  logic        check_ok,
    output int          fail_count,
    output int          outstanding
);
    import zlsd_pkg::*;
    import zipcrypto_tb_pkg::*;

    typedef struct packed {
        logic [7:0] plain;
        logic       done;
        logic       ok;
    } decrypt_result_t;

    // Decryptor state as tracked here
    key_set_t        keys;
    logic [3:0]      hdr_count;
    logic [7:0]      held_byte;
    logic [15:0]     check_value;
    decrypt_result_t expected_results[$];

    // One byte through the cipher: updates the tracked state, returns the result
    function automatic decrypt_result_t predict_byte(input logic f, input logic rs,
                                                     input logic [7:0] d);
        decrypt_result_t r;
        r = '0;
        if (rs)
        begin
            keys      = KEYS_INIT;
            hdr_count = '0;
        end
        if (f == FUNC_PASSWORD)
        begin
            keys = keys_absorb(keys, d);
        end
        else
        begin
            r.plain = d ^ keystream_byte(keys);
            keys    = keys_absorb(keys, r.plain);
            // header count stops at the header length
            if (hdr_count < HDR_FULL)
            begin
                if (hdr_count == HDR_HOLD)
                    held_byte = r.plain;
                if (hdr_count == HDR_LAST)
                begin
                    r.done = 1'b1;
                    r.ok   = ({r.plain, held_byte} == check_value);
                end
                hdr_count = hdr_count + 4'd1;
            end
        end
        return r;
    endfunction

    // Watch both channels and the config port, predict and compare
    always @(posedge clk or negedge rst_n)
    begin : monitor
        decrypt_result_t want;
        if (!rst_n)
        begin
            keys        = KEYS_INIT;
            hdr_count   = '0;
            held_byte   = '0;
            check_value = '0;
            fail_count  = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                check_value = cfg_wr_data;
            if (in_valid && in_ready)
                expected_results.push_back(predict_byte(func, restart, data_byte));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: plain_byte %02h", plain_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (plain_byte !== want.plain)
                    begin
                        $error("plain_byte: expected %02h, got %02h", want.plain, plain_byte);
                        fail_count++;
                    end
                    if (check_done !== want.done)
                    begin
                        $error("check_done: expected %0b, got %0b", want.done, check_done);
                        fail_count++;
                    end
                    if (check_ok !== want.ok)
                    begin
                        $error("check_ok: expected %0b, got %0b", want.ok, check_ok);
                        fail_count++;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: sim/tb_zip_legacy_stream_decrypt.sv
// Testbench top for the legacy ZIP stream decryptor: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_zip_legacy_stream_decrypt;

    import zlsd_pkg::*;
    import zipcrypto_tb_pkg::*;

    localparam int ITEM_TARGET  = 900;
    localparam int NUM_PHASES   = 6;
    localparam int IDLE_PCT     = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic        restart;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  plain_byte;
    logic        check_done;
    logic        check_ok;

    int          fail_count;
    int          pending_results;
    int          bytes_sent;
    int          stall_cycles;
    bit          steady;
    bit          hold_req;
    key_set_t    stream_keys;
    logic [15:0] check_word;

    zip_legacy_stream_decrypt u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .restart    (restart),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .plain_byte (plain_byte),
        .check_done (check_done),
        .check_ok   (check_ok)
    );

    zipcrypto_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .restart    (restart),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .plain_byte (plain_byte),
        .check_done (check_done),
        .check_ok   (check_ok),
        .fail_count (fail_count),
        .outstanding(pending_results)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one byte and hold it until the transfer; keys are tracked for encryption
    task automatic send_byte(input logic f, input logic rs, input logic [7:0] d);
        logic [7:0] pb;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        restart   <= rs;
        data_byte <= d;
        do @(posedge clk); while (!in_ready);
        if (rs)
            stream_keys = KEYS_INIT;
        if (f == FUNC_CIPHER)
        begin
            pb          = d ^ keystream_byte(stream_keys);
            stream_keys = keys_absorb(stream_keys, pb);
        end
        else
        begin
            stream_keys = keys_absorb(stream_keys, d);
        end
        bytes_sent++;
    endtask

    // Encrypt a chosen plain byte under the current keys and send it
    task automatic send_plain(input logic rs, input logic [7:0] pb);
        key_set_t ks;
        ks = rs ? KEYS_INIT : stream_keys;
        send_byte(FUNC_CIPHER, rs, pb ^ keystream_byte(ks));
    endtask

    // Change the expected check once the decryptor has drained
    task automatic write_check(input logic [15:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        check_word = value;
    endtask

    // Short hand-picked stream, check value still at its reset of zero
    task automatic directed_stream();
        send_byte(FUNC_PASSWORD, 1'b1, 8'h00);
        send_byte(FUNC_PASSWORD, 1'b0, 8'hFF);
        for (int i = 0; i < HEADER_LEN; i++)
        begin
            // password byte in the middle of the header
            if (i == 4)
                send_byte(FUNC_PASSWORD, 1'b0, 8'hA5);
            if (i == 0)
                send_byte(FUNC_CIPHER, 1'b0, 8'h00);
            else if (i == 1)
                send_byte(FUNC_CIPHER, 1'b0, 8'hFF);
            else if (i >= HDR_HOLD)
                send_plain(1'b0, 8'h00);
            else
                send_plain(1'b0, 8'($urandom_range(0, 255)));
        end
        // past the header: count saturated
        send_byte(FUNC_CIPHER, 1'b0, 8'hFF);
        send_byte(FUNC_CIPHER, 1'b0, 8'h00);
        // restart on a cipher byte, then on a password byte
        send_byte(FUNC_CIPHER, 1'b1, 8'h3C);
        send_byte(FUNC_PASSWORD, 1'b1, 8'h5A);
    endtask

    // One random stream: mostly password, header and data; some noise
    task automatic random_stream();
        int          kind;
        int          n;
        bit          cipher_start;
        logic [15:0] hdr_word;
        logic [7:0]  pb;
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
                send_byte(1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                          8'($urandom_range(0, 255)));
        end
        else
        begin
            cipher_start = (kind < 30);
            if (!cipher_start)
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    send_byte(FUNC_PASSWORD, (i == 0), 8'($urandom_range(0, 255)));
            end
            // header bytes 11:10 usually carry the check value
            hdr_word = check_word;
            if ($urandom_range(0, 3) == 0)
                hdr_word = hdr_word ^ (16'h1 << $urandom_range(0, 15));
            for (int i = 0; i < HEADER_LEN; i++)
            begin
                if (i > 0 && $urandom_range(0, 9) == 0)
                    send_byte(FUNC_PASSWORD, 1'b0, 8'($urandom_range(0, 255)));
                if (i == HDR_HOLD)
                    pb = hdr_word[7:0];
                else if (i == HDR_LAST)
                    pb = hdr_word[15:8];
                else
                    pb = 8'($urandom_range(0, 255));
                send_plain(cipher_start && i == 0, pb);
            end
            n = $urandom_range(0, 15);
            repeat (n)
                send_byte(FUNC_CIPHER, 1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [15:0] phase_check;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        func        = FUNC_PASSWORD;
        restart     = 1'b0;
        data_byte   = '0;
        bytes_sent  = 0;
        steady      = 1'b0;
        hold_req    = 1'b0;
        stream_keys = KEYS_INIT;
        check_word  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_stream();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       phase_check = 16'hFFFF;
                1:       phase_check = 16'h0000;
                default: phase_check = 16'($urandom_range(0, 65535));
            endcase
            write_check(phase_check);
            // one phase with no idling, one with a long receiver hold-off
            steady = (ph == 2);
            if (ph == 3)
                hold_req = 1'b1;
            while (bytes_sent < (ph + 1) * ITEM_TARGET / NUM_PHASES)
                random_stream();
        end
        steady = 1'b0;

        // drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Result side flow control
    initial
    begin
        bit hold_taken;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

FILE: files.f
hdl/zlsd_pkg.sv
hdl/zlsd_ctrl.sv
hdl/zlsd_dp.sv
hdl/zip_legacy_stream_decrypt.sv
hdl/zlsd_checker.sv
sim/zipcrypto_result_checker.sv
sim/tb_zip_legacy_stream_decrypt.sv
